// File: hdl/assert_macros.svh
// Assertion macros used by the cascade PID sequencer.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CPVP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Cause in one cycle implies effect in the next cycle.
`define CPVP_ASSERT_NEXT(label, clk, rst_n, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);

`endif

// File: hdl/cpvp_pkg.sv
// Shared types, constants and the control program of the cascade PID unit.
// No dependencies; imported by the sequencer, the datapath and the top level.
`timescale 1ns / 1ps

package cpvp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int GAIN_W        = 31;
    localparam int CFG_IDX_W     = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KP_POS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP_VEL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KI_DT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KD_OVER_DT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_LIMIT  = 3'd4;

    // Register reset values
    localparam logic [GAIN_W-1:0] KP_POS_RST     = 31'd262144;
    localparam logic [GAIN_W-1:0] KP_VEL_RST     = 31'd655360;
    localparam logic [GAIN_W-1:0] KI_DT_RST      = 31'd3277;
    localparam logic [GAIN_W-1:0] KD_OVER_DT_RST = 31'd6553600;
    localparam logic [GAIN_W-1:0] VEL_LIMIT_RST  = 31'd131072;

    typedef struct packed {
        logic [GAIN_W-1:0] kp_pos;
        logic [GAIN_W-1:0] kp_vel;
        logic [GAIN_W-1:0] ki_dt;
        logic [GAIN_W-1:0] kd_over_dt;
        logic [GAIN_W-1:0] vel_limit;
    } cfg_t;

    // Magnitude unit source
    typedef enum logic [1:0] {
        MAG_NONE,
        MAG_PERR,
        MAG_VERR,
        MAG_DER
    } mag_sel_t;

    // Multiplier gain select
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_KP_POS,
        MUL_KP_VEL,
        MUL_KI,
        MUL_KD
    } mul_sel_t;

    // Adder / saturation unit operation
    typedef enum logic [2:0] {
        ALU_NONE,
        ALU_VSP,
        ALU_VERR,
        ALU_ACC_LOAD,
        ALU_ACC_ADD,
        ALU_INTEG,
        ALU_FINISH
    } alu_op_t;

    // Sequencing of the step counter
    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_WAIT_IN,
        SEQ_WAIT_OUT,
        SEQ_JUMP
    } seq_op_t;

    localparam int UCODE_LEN = 11;
    localparam int STEP_W    = $clog2(UCODE_LEN);

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE = '0;

    typedef struct packed {
        seq_op_t  seq;
        step_t    target;
        mag_sel_t mag_sel;
        mul_sel_t mul_sel;
        alu_op_t  alu_op;
    } uword_t;

    typedef struct packed {
        logic     load_in;
        mag_sel_t mag_sel;
        mul_sel_t mul_sel;
        alu_op_t  alu_op;
    } dp_ctrl_t;

    // Control program. Multiply and accumulate overlap: the product of one
    // step is scaled and summed in the next while the next product runs.
    function automatic uword_t ucode_word(input step_t step);
        uword_t w;
        case (step)
            step_t'(0):  w = '{SEQ_WAIT_IN,  STEP_IDLE, MAG_NONE, MUL_NONE,   ALU_NONE};
            step_t'(1):  w = '{SEQ_NEXT,     STEP_IDLE, MAG_PERR, MUL_NONE,   ALU_NONE};
            step_t'(2):  w = '{SEQ_NEXT,     STEP_IDLE, MAG_NONE, MUL_KP_POS, ALU_NONE};
            step_t'(3):  w = '{SEQ_NEXT,     STEP_IDLE, MAG_NONE, MUL_NONE,   ALU_VSP};
            step_t'(4):  w = '{SEQ_NEXT,     STEP_IDLE, MAG_NONE, MUL_NONE,   ALU_VERR};
            step_t'(5):  w = '{SEQ_NEXT,     STEP_IDLE, MAG_VERR, MUL_NONE,   ALU_NONE};
            step_t'(6):  w = '{SEQ_NEXT,     STEP_IDLE, MAG_DER,  MUL_KP_VEL, ALU_NONE};
            step_t'(7):  w = '{SEQ_NEXT,     STEP_IDLE, MAG_VERR, MUL_KD,     ALU_ACC_LOAD};
            step_t'(8):  w = '{SEQ_NEXT,     STEP_IDLE, MAG_NONE, MUL_KI,     ALU_ACC_ADD};
            step_t'(9):  w = '{SEQ_NEXT,     STEP_IDLE, MAG_NONE, MUL_NONE,   ALU_INTEG};
            step_t'(10): w = '{SEQ_WAIT_OUT, STEP_IDLE, MAG_NONE, MUL_NONE,   ALU_FINISH};
            default:     w = '{SEQ_JUMP,     STEP_IDLE, MAG_NONE, MUL_NONE,   ALU_NONE};
        endcase
        return w;
    endfunction

endpackage

// File: hdl/cpvp_sequencer.sv
// Step counter and control store of the cascade PID unit; owns both handshakes.
// Depends on cpvp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpvp_sequencer
    import cpvp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output dp_ctrl_t ctrl
);

    step_t  step_reg, step_next;
    logic   out_valid_reg, out_valid_next;
    uword_t word;
    logic   fire;
    logic   finish;

    always_comb
    begin
        word      = ucode_word(step_reg);
        fire      = 1'b0;
        in_ready  = 1'b0;
        step_next = step_reg;
        case (word.seq)
            SEQ_NEXT:
            begin
                fire      = 1'b1;
                step_next = step_t'(step_reg + 1'b1);
            end
            SEQ_WAIT_IN:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    fire      = 1'b1;
                    step_next = step_t'(step_reg + 1'b1);
                end
            end
            SEQ_WAIT_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    fire      = 1'b1;
                    step_next = word.target;
                end
            end
            SEQ_JUMP:
            begin
                fire      = 1'b1;
                step_next = word.target;
            end
            default:
            begin
                step_next = STEP_IDLE;
            end
        endcase

        finish         = fire && (word.alu_op == ALU_FINISH);
        out_valid_next = finish || (out_valid_reg && !out_ready);

        ctrl.load_in = in_ready && in_valid;
        ctrl.mag_sel = fire ? word.mag_sel : MAG_NONE;
        ctrl.mul_sel = fire ? word.mul_sel : MUL_NONE;
        ctrl.alu_op  = fire ? word.alu_op  : ALU_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `CPVP_ASSERT(a_no_overwrite, clk, rst_n, finish |-> (!out_valid_reg || out_ready), "result overwritten before taken")
    `CPVP_ASSERT_NEXT(a_finish_shows, clk, rst_n, finish, out_valid_reg, "finished transaction not presented")
    `CPVP_ASSERT_NEXT(a_accept_advances, clk, rst_n, ctrl.load_in, step_reg == step_t'(STEP_IDLE + 1'b1), "accept did not start program")
    `CPVP_ASSERT(a_step_range, clk, rst_n, step_reg < step_t'(UCODE_LEN), "step counter left program")

endmodule

// File: hdl/cpvp_datapath.sv
// Datapath of the cascade PID unit: magnitude unit, shared 32x31 multiplier,
// adder/saturation unit and loop state. Depends on cpvp_pkg.
`timescale 1ns / 1ps

module cpvp_datapath
    import cpvp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_ctrl_t                 ctrl,
    input  cfg_t                     cfg,
    input  logic signed [DATA_W-1:0] position_target,
    input  logic signed [DATA_W-1:0] position_meas,
    input  logic signed [DATA_W-1:0] velocity_meas,
    output logic signed [DATA_W-1:0] drive,
    output logic signed [DATA_W-1:0] velocity_setpoint,
    output logic                     velocity_limited,
    output logic                     drive_saturated
);

    localparam int PROD_W = DATA_W + GAIN_W;
    localparam int ACC_W  = PROD_W + 3 - FRAC_BITS;

    localparam logic signed [ACC_W-1:0] S32_MAX =
        {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] S32_MIN =
        {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    function automatic logic signed [ACC_W-1:0] sx(input logic signed [DATA_W-1:0] v);
        return {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    function automatic logic ovf32(input logic signed [ACC_W-1:0] v);
        return (v > S32_MAX) || (v < S32_MIN);
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > S32_MAX)
            r = S32_MAX[DATA_W-1:0];
        else if (v < S32_MIN)
            r = S32_MIN[DATA_W-1:0];
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    // latched transaction and intermediate values
    logic signed [DATA_W-1:0] tgt_reg, pmeas_reg, vmeas_reg;
    logic signed [DATA_W-1:0] vsp_reg, vsp_next;
    logic signed [DATA_W-1:0] verr_reg, verr_next;
    logic signed [DATA_W-1:0] integ_new_reg;
    logic [DATA_W-1:0]        mag_reg, mag_next;
    logic                     neg_reg, neg_next;
    logic [PROD_W-1:0]        prod_reg;
    logic                     prod_neg_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     vlim_reg, vlim_next;
    logic                     isat_reg;

    // loop state
    logic signed [DATA_W-1:0] integ_reg;
    logic signed [DATA_W-1:0] prev_reg;

    logic signed [DATA_W-1:0] mag_a, mag_b;
    logic signed [DATA_W:0]   diff_ab, diff_ba, verr_neg;
    logic                     a_lt_b;
    logic [GAIN_W-1:0]        gain;
    logic signed [ACC_W-1:0]  scaled, sterm, lim_pos, lim_neg;
    logic signed [DATA_W:0]   verr_raw;
    logic signed [ACC_W-1:0]  integ_sum, drive_sum;

    // magnitude and sign of the next multiplier operand
    always_comb
    begin
        mag_a    = (ctrl.mag_sel == MAG_DER) ? verr_reg : tgt_reg;
        mag_b    = (ctrl.mag_sel == MAG_DER) ? prev_reg : pmeas_reg;
        diff_ab  = {mag_a[DATA_W-1], mag_a} - {mag_b[DATA_W-1], mag_b};
        diff_ba  = {mag_b[DATA_W-1], mag_b} - {mag_a[DATA_W-1], mag_a};
        a_lt_b   = mag_a < mag_b;
        verr_neg = -{verr_reg[DATA_W-1], verr_reg};
        mag_next = mag_reg;
        neg_next = neg_reg;
        case (ctrl.mag_sel)
            MAG_PERR, MAG_DER:
            begin
                mag_next = a_lt_b ? diff_ba[DATA_W-1:0] : diff_ab[DATA_W-1:0];
                neg_next = a_lt_b;
            end
            MAG_VERR:
            begin
                neg_next = verr_reg[DATA_W-1];
                mag_next = verr_reg[DATA_W-1] ? verr_neg[DATA_W-1:0] : verr_reg;
            end
            default:
            begin
                mag_next = mag_reg;
            end
        endcase
    end

    always_comb
    begin
        case (ctrl.mul_sel)
            MUL_KP_POS: gain = cfg.kp_pos;
            MUL_KP_VEL: gain = cfg.kp_vel;
            MUL_KI:     gain = cfg.ki_dt;
            MUL_KD:     gain = cfg.kd_over_dt;
            default:    gain = '0;
        endcase
    end

    // scaled signed term: magnitude truncated, then sign applied
    always_comb
    begin
        scaled  = $signed(ACC_W'(prod_reg >> FRAC_BITS));
        sterm   = prod_neg_reg ? -scaled : scaled;
        lim_pos = $signed(ACC_W'(cfg.vel_limit));
        lim_neg = -lim_pos;

        vsp_next  = sterm[DATA_W-1:0];
        vlim_next = 1'b0;
        if (sterm > lim_pos)
        begin
            vsp_next  = lim_pos[DATA_W-1:0];
            vlim_next = 1'b1;
        end
        else if (sterm < lim_neg)
        begin
            vsp_next  = lim_neg[DATA_W-1:0];
            vlim_next = 1'b1;
        end

        verr_raw = {vsp_reg[DATA_W-1], vsp_reg} - {vmeas_reg[DATA_W-1], vmeas_reg};
        if (verr_raw[DATA_W] != verr_raw[DATA_W-1])
            verr_next = verr_raw[DATA_W] ? S32_MIN[DATA_W-1:0] : S32_MAX[DATA_W-1:0];
        else
            verr_next = verr_raw[DATA_W-1:0];

        integ_sum = sx(integ_reg) + sterm;
        drive_sum = acc_reg + sx(integ_new_reg);
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            tgt_reg   <= position_target;
            pmeas_reg <= position_meas;
            vmeas_reg <= velocity_meas;
        end
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        if (ctrl.mul_sel != MUL_NONE)
        begin
            prod_reg     <= PROD_W'(mag_reg) * PROD_W'(gain);
            prod_neg_reg <= neg_reg;
        end
        case (ctrl.alu_op)
            ALU_VSP:
            begin
                vsp_reg  <= vsp_next;
                vlim_reg <= vlim_next;
            end
            ALU_VERR:
            begin
                verr_reg <= verr_next;
            end
            ALU_ACC_LOAD:
            begin
                acc_reg <= sterm;
            end
            ALU_ACC_ADD:
            begin
                acc_reg <= acc_reg + sterm;
            end
            ALU_INTEG:
            begin
                integ_new_reg <= sat32(integ_sum);
                isat_reg      <= ovf32(integ_sum);
            end
            ALU_FINISH:
            begin
                drive             <= sat32(drive_sum);
                drive_saturated   <= isat_reg || ovf32(drive_sum);
                velocity_setpoint <= vsp_reg;
                velocity_limited  <= vlim_reg;
            end
            default:
            begin
            end
        endcase
    end

    // loop state, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
            prev_reg  <= '0;
        end
        else if (ctrl.alu_op == ALU_FINISH)
        begin
            integ_reg <= integ_new_reg;
            prev_reg  <= verr_reg;
        end
    end

endmodule

// File: hdl/cascade_position_velocity_pid_unit.sv
// Cascade position/velocity controller: outer P loop on position, inner PID on velocity.
// One transaction at a time: the 11-step control program runs four products through
//   one shared 32x31 multiplier, and the next input is taken only back at the idle step.
// Reset: async, active low; clears integrator, previous error, handshakes; loads defaults.
// Depends on cpvp_pkg, cpvp_sequencer and cpvp_datapath.
`timescale 1ns / 1ps

module cascade_position_velocity_pid_unit
    import cpvp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    // configuration write port
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_idx,
    input  logic [GAIN_W-1:0]        cfg_wdata,

    // input transaction
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] position_target,
    input  logic signed [DATA_W-1:0] position_meas,
    input  logic signed [DATA_W-1:0] velocity_meas,

    // result transaction
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] drive,
    output logic signed [DATA_W-1:0] velocity_setpoint,
    output logic                     velocity_limited,
    output logic                     drive_saturated
);

    cfg_t     cfg_reg;
    dp_ctrl_t ctrl;

    // Configuration registers, read by the datapath directly without a shadow
    // copy. The user must make writes only while the block is idle; the block
    // itself does not enforce this. An index beyond the register list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_pos     <= KP_POS_RST;
            cfg_reg.kp_vel     <= KP_VEL_RST;
            cfg_reg.ki_dt      <= KI_DT_RST;
            cfg_reg.kd_over_dt <= KD_OVER_DT_RST;
            cfg_reg.vel_limit  <= VEL_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_KP_POS:     cfg_reg.kp_pos     <= cfg_wdata;
                REG_KP_VEL:     cfg_reg.kp_vel     <= cfg_wdata;
                REG_KI_DT:      cfg_reg.ki_dt      <= cfg_wdata;
                REG_KD_OVER_DT: cfg_reg.kd_over_dt <= cfg_wdata;
                REG_VEL_LIMIT:  cfg_reg.vel_limit  <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer: step counter over the control program. It takes a new
    // transaction at the idle step even while the previous result still
    // waits in the output register; the last step holds only if that
    // register is still occupied.
    cpvp_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctrl      (ctrl)
    );

    // Datapath: operand magnitude, shared multiplier, accumulate and
    // saturate, plus integrator and previous velocity error.
    cpvp_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctrl              (ctrl),
        .cfg               (cfg_reg),
        .position_target   (position_target),
        .position_meas     (position_meas),
        .velocity_meas     (velocity_meas),
        .drive             (drive),
        .velocity_setpoint (velocity_setpoint),
        .velocity_limited  (velocity_limited),
        .drive_saturated   (drive_saturated)
    );

endmodule

// File: tb/tb.sv
// Self-checking testbench for the cascade position/velocity PID unit.
// Depends on cpvp_pkg and cascade_position_velocity_pid_unit; checks every result
// against a cycle-free predictor of the outer P loop and the inner PID.
`timescale 1ns / 1ps

module tb;
    import cpvp_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 12;
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};

    // One expected tick result
    typedef struct {
        logic signed [DATA_W-1:0] drive;
        logic signed [DATA_W-1:0] velocity_setpoint;
        logic                     velocity_limited;
        logic                     drive_saturated;
    } tick_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_idx;
    logic [GAIN_W-1:0]        cfg_wdata;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [DATA_W-1:0] position_target;
    logic signed [DATA_W-1:0] position_meas;
    logic signed [DATA_W-1:0] velocity_meas;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DATA_W-1:0] drive;
    logic signed [DATA_W-1:0] velocity_setpoint;
    logic                     velocity_limited;
    logic                     drive_saturated;

    // Predictor state: gains and the two loop memories
    cfg_t                     gains;
    logic signed [DATA_W-1:0] integ_state;
    logic signed [DATA_W-1:0] prev_verr_state;

    tick_result_t             expected_ticks[$];

    int  err_count;
    int  ticks_sent;
    int  ticks_checked;
    int  gain_writes;
    int  idle_cycles;
    int  rx_hold_left;
    int  rx_gap_left;
    bit  tx_idle_en;
    bit  rx_idle_en;

    cascade_position_velocity_pid_unit uut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_idx           (cfg_idx),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .position_target   (position_target),
        .position_meas     (position_meas),
        .velocity_meas     (velocity_meas),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .drive             (drive),
        .velocity_setpoint (velocity_setpoint),
        .velocity_limited  (velocity_limited),
        .drive_saturated   (drive_saturated)
    );

    always #10 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Gain times value, shifted down by the fraction bits with the magnitude
    // truncated (round toward zero). The product can exceed 64 bits, so
    // form it at 96 bits.
    function automatic longint gain_scale(input longint value, input logic [GAIN_W-1:0] k);
        logic        neg;
        logic [95:0] mag;
        logic [95:0] prod;
        neg  = (value < 0);
        mag  = neg ? 96'(-value) : 96'(value);
        prod = (mag * {65'd0, k}) >> FRAC_BITS_DEF;
        return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    // Clip to the signed 32-bit range and report whether it clipped
    function automatic longint clip32(input longint value, output bit hit);
        hit = 1'b0;
        if (value > longint'(Q_MAX))
        begin
            hit = 1'b1;
            return longint'(Q_MAX);
        end
        if (value < longint'(Q_MIN))
        begin
            hit = 1'b1;
            return longint'(Q_MIN);
        end
        return value;
    endfunction

    // Advance the predictor by one control tick
    function automatic tick_result_t predict_tick(input logic signed [DATA_W-1:0] tgt,
                                                  input logic signed [DATA_W-1:0] pmeas,
                                                  input logic signed [DATA_W-1:0] vmeas);
        tick_result_t res;
        longint       pos_err;
        longint       vsp_raw;
        longint       vsp;
        longint       lim;
        longint       verr;
        longint       integ;
        longint       delta;
        longint       sum;
        bit           hit_verr;
        bit           hit_integ;
        bit           hit_drive;
        logic         clamped;

        // Outer loop: the 33-bit position error is kept exactly
        pos_err = longint'(tgt) - longint'(pmeas);
        vsp_raw = gain_scale(pos_err, gains.kp_pos);
        lim     = longint'({1'b0, gains.vel_limit});
        clamped = 1'b0;
        vsp     = vsp_raw;
        if (vsp_raw > lim)
        begin
            vsp     = lim;
            clamped = 1'b1;
        end
        else if (vsp_raw < -lim)
        begin
            vsp     = -lim;
            clamped = 1'b1;
        end

        // Inner loop: a clipped velocity error does not flag saturation
        verr  = clip32(vsp - longint'(vmeas), hit_verr);
        integ = clip32(longint'(integ_state) + gain_scale(verr, gains.ki_dt), hit_integ);
        delta = verr - longint'(prev_verr_state);
        sum   = gain_scale(verr, gains.kp_vel) + integ + gain_scale(delta, gains.kd_over_dt);
        sum   = clip32(sum, hit_drive);

        integ_state     = DATA_W'(integ);
        prev_verr_state = DATA_W'(verr);

        res.drive             = DATA_W'(sum);
        res.velocity_setpoint = DATA_W'(vsp);
        res.velocity_limited  = clamped;
        res.drive_saturated   = hit_integ | hit_drive;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Monitor: predict on each accepted input transaction, check each
    // accepted result transaction against the oldest expectation.
    // Sample pre-edge values so the order of events in the step is moot.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        tick_result_t exp_res;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_ticks.size() == 0)
                begin
                    $error("unexpected result transaction: drive %0d", drive);
                    err_count++;
                end
                else
                begin
                    exp_res = expected_ticks.pop_front();
                    if (drive !== exp_res.drive)
                    begin
                        $error("drive: expected %0d, got %0d", exp_res.drive, drive);
                        err_count++;
                    end
                    if (velocity_setpoint !== exp_res.velocity_setpoint)
                    begin
                        $error("velocity_setpoint: expected %0d, got %0d",
                               exp_res.velocity_setpoint, velocity_setpoint);
                        err_count++;
                    end
                    if (velocity_limited !== exp_res.velocity_limited)
                    begin
                        $error("velocity_limited: expected %0b, got %0b",
                               exp_res.velocity_limited, velocity_limited);
                        err_count++;
                    end
                    if (drive_saturated !== exp_res.drive_saturated)
                    begin
                        $error("drive_saturated: expected %0b, got %0b",
                               exp_res.drive_saturated, drive_saturated);
                        err_count++;
                    end
                end
                ticks_checked++;
            end
            if (in_valid && in_ready)
                expected_ticks.push_back(predict_tick(position_target, position_meas,
                                                      velocity_meas));
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Result side: a long hold when asked, otherwise random stall bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                out_ready <= 1'b0;
            end
            else if (rx_gap_left > 0)
            begin
                rx_gap_left--;
                out_ready <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 4) == 0)
            begin
                rx_gap_left = $urandom_range(1, 15) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Shared sender tasks
    // ---------------------------------------------------------------

    // Offer one tick, after an optional idle burst; return at the accepting edge
    // with in_valid still high so a following tick can go back to back.
    task automatic send_tick(input logic signed [DATA_W-1:0] tgt,
                             input logic signed [DATA_W-1:0] pmeas,
                             input logic signed [DATA_W-1:0] vmeas);
        int gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        position_target <= tgt;
        position_meas   <= pmeas;
        velocity_meas   <= vmeas;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ticks_sent++;
    endtask

    // Drop valid and wait until every result has been checked
    task automatic drain_ticks();
        if (in_valid)
            in_valid <= 1'b0;
        while (ticks_checked < ticks_sent)
            @(posedge clk);
    endtask

    // Write one gain register and mirror it into the predictor
    task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_KP_POS:     gains.kp_pos     = val;
            REG_KP_VEL:     gains.kp_vel     = val;
            REG_KI_DT:      gains.ki_dt      = val;
            REG_KD_OVER_DT: gains.kd_over_dt = val;
            REG_VEL_LIMIT:  gains.vel_limit  = val;
            default: ;
        endcase
        gain_writes++;
    endtask

    // Drain, then load all five registers
    task automatic load_gains(input logic [GAIN_W-1:0] kpp, input logic [GAIN_W-1:0] kpv,
                              input logic [GAIN_W-1:0] ki,  input logic [GAIN_W-1:0] kd,
                              input logic [GAIN_W-1:0] lim);
        drain_ticks();
        write_gain(REG_KP_POS, kpp);
        write_gain(REG_KP_VEL, kpv);
        write_gain(REG_KI_DT, ki);
        write_gain(REG_KD_OVER_DT, kd);
        write_gain(REG_VEL_LIMIT, lim);
        cfg_we <= 1'b0;
    endtask

    // Q16.16 value: mostly plant-like magnitudes, some extremes and raw noise
    function automatic logic signed [DATA_W-1:0] rand_q();
        case ($urandom_range(0, 9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2, 3, 4: return DATA_W'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
            5, 6:    return DATA_W'($signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000);
            default: return $urandom;
        endcase
    endfunction

    // Gain: zero, full scale, a realistic gain or raw bits
    function automatic logic [GAIN_W-1:0] rand_gain();
        case ($urandom_range(0, 7))
            0:          return '0;
            1:          return GAIN_MAX;
            2, 3, 4, 5: return GAIN_W'($urandom_range(0, 32'h0040_0000));
            default:    return GAIN_W'($urandom);
        endcase
    endfunction

    // A run of ticks that follows a moving target, with noise mixed in
    task automatic send_trajectory(input int count);
        logic signed [DATA_W-1:0] tgt;
        logic signed [DATA_W-1:0] pos;
        logic signed [DATA_W-1:0] vel;
        tgt = rand_q();
        pos = tgt - DATA_W'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
        vel = DATA_W'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
        repeat (count)
        begin
            if ($urandom_range(0, 5) == 0)
                send_tick(rand_q(), rand_q(), rand_q());
            else
            begin
                send_tick(tgt, pos, vel);
                pos = pos + (vel >>> 4);
                vel = vel + DATA_W'($signed($urandom_range(0, 32'h0000_4000)) - 32'sh2000);
                if ($urandom_range(0, 7) == 0)
                    tgt = tgt + DATA_W'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset gains, first tick with zero previous error, zero inputs
    task automatic test_reset_defaults();
        send_tick(32'sh0001_0000, 32'sh0000_0000, 32'sh0000_0000);
        send_tick(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
        send_tick(32'sh0000_8000, 32'sh0000_4000, -32'sh0000_2000);
        send_tick(-32'sh0002_0000, 32'sh0001_0000, 32'sh0000_1000);
        drain_ticks();
    endtask

    // Field extremes: wide position error, clipped velocity error
    task automatic test_field_extremes();
        send_tick(Q_MAX, Q_MIN, 32'sh0000_0000);
        send_tick(Q_MIN, Q_MAX, 32'sh0000_0000);
        send_tick(Q_MAX, Q_MIN, Q_MIN);
        send_tick(Q_MIN, Q_MAX, Q_MAX);
        send_tick(Q_MAX, Q_MAX, Q_MAX);
        send_tick(Q_MIN, Q_MIN, Q_MIN);
        send_tick(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0001);
        send_tick(32'shFFFF_FFFF, 32'sh0000_0000, 32'shFFFF_FFFF);
        // Full-scale limit lets the velocity error clip on both sides
        load_gains(GAIN_MAX, KP_VEL_RST, KI_DT_RST, KD_OVER_DT_RST, GAIN_MAX);
        send_tick(Q_MAX, Q_MIN, Q_MIN);
        send_tick(Q_MIN, Q_MAX, Q_MAX);
        drain_ticks();
    endtask

    // Integrator overflow in both directions, then zero gains
    task automatic test_integrator_overflow();
        load_gains(KP_POS_RST, '0, GAIN_MAX, '0, VEL_LIMIT_RST);
        send_tick(32'sh0000_0000, 32'sh0000_0000, Q_MIN);
        send_tick(32'sh0000_0000, 32'sh0000_0000, Q_MIN);
        send_tick(32'sh0000_0000, 32'sh0000_0000, Q_MAX);
        send_tick(32'sh0000_0000, 32'sh0000_0000, Q_MAX);
        load_gains('0, '0, '0, '0, '0);
        send_tick(Q_MAX, Q_MIN, 32'sh0001_0000);
        send_tick(32'sh0001_0000, 32'sh0000_0000, 32'sh0000_0000);
        drain_ticks();
    endtask

    // Registers at their extremes in several mixes, others at reset values, then all at full scale
    task automatic test_register_sweep();
        load_gains(GAIN_MAX, KP_VEL_RST, KI_DT_RST, KD_OVER_DT_RST, VEL_LIMIT_RST);
        send_trajectory(40);
        load_gains(KP_POS_RST, GAIN_MAX, '0, KD_OVER_DT_RST, GAIN_MAX);
        send_trajectory(40);
        load_gains(KP_POS_RST, KP_VEL_RST, GAIN_MAX, '0, VEL_LIMIT_RST);
        send_trajectory(40);
        load_gains('0, KP_VEL_RST, KI_DT_RST, GAIN_MAX, '0);
        send_trajectory(40);
        load_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
        send_trajectory(40);
        drain_ticks();
    endtask

    // Random gain settings, each followed by a burst of ticks
    task automatic test_random_gains();
        repeat (6)
        begin
            load_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain());
            send_trajectory(50);
        end
        drain_ticks();
    endtask

    // Hold the result side off while ticks keep coming, so the unit stalls
    task automatic test_backpressure();
        load_gains(KP_POS_RST, KP_VEL_RST, KI_DT_RST, KD_OVER_DT_RST, VEL_LIMIT_RST);
        rx_hold_left = 300;
        send_trajectory(30);
        drain_ticks();
    endtask

    // No idling on either side for the closing stretch
    task automatic test_streaming();
        load_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain());
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_trajectory(80);
        drain_ticks();
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_wdata       = '0;
        in_valid        = 1'b0;
        position_target = '0;
        position_meas   = '0;
        velocity_meas   = '0;
        out_ready       = 1'b0;
        gains           = '{KP_POS_RST, KP_VEL_RST, KI_DT_RST, KD_OVER_DT_RST, VEL_LIMIT_RST};
        integ_state     = '0;
        prev_verr_state = '0;
        err_count       = 0;
        ticks_sent      = 0;
        ticks_checked   = 0;
        gain_writes     = 0;
        idle_cycles     = 0;
        rx_hold_left    = 0;
        rx_gap_left     = 0;
        tx_idle_en      = 1'b1;
        rx_idle_en      = 1'b1;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_field_extremes();
        test_integrator_overflow();
        test_register_sweep();
        test_random_gains();
        test_backpressure();
        test_streaming();

        // Let any stray result show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_ticks.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_ticks.size());
            err_count++;
        end

        $display("Checked %0d control ticks across %0d register writes, covering clamping,",
                 ticks_checked, gain_writes);
        $display("integrator and drive saturation, random stalls and a long result hold.");
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
